FILE: hdl/wavdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wavdec_pkg;
    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_FMT  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_PAD  = 3'd5;
    localparam logic [2:0] PH_ERR  = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_HEADER    = 4'd1;
    localparam logic [3:0] ST_TRUNC     = 4'd2;
    localparam logic [3:0] ST_FMT_SMALL = 4'd3;
    localparam logic [3:0] ST_NO_FMT    = 4'd4;
    localparam logic [3:0] ST_NO_DATA   = 4'd5;
    localparam logic [3:0] ST_FMT_CODE  = 4'd6;
    localparam logic [3:0] ST_CHANNELS  = 4'd7;
    localparam logic [3:0] ST_RATE      = 4'd8;
    localparam logic [3:0] ST_DEPTH     = 4'd9;
    localparam logic [3:0] ST_ALIGN     = 4'd10;
    localparam logic [3:0] ST_SIZE      = 4'd11;
    localparam logic [3:0] ST_PCM_DEPTH = 4'd12;
    localparam logic [3:0] ST_FLT_DEPTH = 4'd13;
    localparam logic [3:0] ST_NONFINITE = 4'd14;
    localparam logic [3:0] ST_DUPLICATE = 4'd15;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // Float to Q0.31, truncation toward zero, clamped to [-1, 1].
    function automatic logic [31:0] float_to_q31(input logic [31:0] raw);
        logic [7:0]  e;
        logic [31:0] m;
        logic [31:0] mag;
        e   = raw[30:23];
        m   = {8'd0, 1'b1, raw[22:0]};
        mag = 32'd0;
        if (e >= 8'd119) begin
            mag = m << (e - 8'd119);
        end else if ((8'd119 - e) < 8'd24) begin
            mag = m >> (8'd119 - e);
        end
        if (e == 8'd0) begin
            float_to_q31 = 32'd0;
        end else if (e >= 8'd127) begin
            float_to_q31 = raw[31] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            float_to_q31 = raw[31] ? (32'd0 - mag) : mag;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hdl/wavdec_modchk.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring remainder of a 32-bit size by a 16-bit divisor, one bit per cycle.
module wavdec_modchk
    import wavdec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             busy,
    output logic             done,
    output logic             rem_zero
);
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {2'b00, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd0;
                quo_reg   <= dividend;
                rem_reg   <= 17'd0;
            end else if (busy_reg) begin
                if (!trial[17]) begin
                    rem_reg <= trial[16:0];
                end else begin
                    rem_reg <= {rem_reg[15:0], quo_reg[31]};
                end
                quo_reg   <= {quo_reg[30:0], 1'b0};
                count_reg <= count_reg + 6'd1;
                if (count_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign rem_zero = (rem_reg == 17'd0);
endmodule
`default_nettype wire

FILE: hdl/wav_stream_sample_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is registered in the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle while the result register is free. The last byte of
// a data chunk header is held while the bit-serial divider checks the size against
// the block alignment, when the other header checks pass.
// Reset: aresetn is synchronous and active low; it returns the parser to the RIFF
// header and clears all captured format fields. The last byte of a file does too.
module wav_stream_sample_decoder_core
    import wavdec_pkg::*;
#(
    parameter int MAX_CHANNEL_COUNT = 254
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_sample_valid,
    output logic [31:0]      m_sample_value,
    output logic [7:0]       m_channel_index,
    output logic             m_frame_end,
    output logic [7:0]       m_channel_count,
    output logic [31:0]      m_rate_hz,
    output logic             m_file_done,
    output logic [3:0]       m_status
);
    localparam logic [15:0] MaxCh = 16'(MAX_CHANNEL_COUNT);

    // Parser state.
    logic [3:0]  pos_reg;
    logic [2:0]  phase_reg;
    logic [63:0] hdr_reg;
    logic [32:0] rem_reg;
    logic        pad_reg;
    logic [15:0] fcode_reg, chans_reg, align_reg, bits_reg;
    logic [31:0] rate_reg;
    logic [1:0]  seen_reg;
    logic [31:0] asm_reg;
    logic [1:0]  nbyte_reg;
    logic [7:0]  chan_reg;
    logic [3:0]  err_reg;

    // Data header check sequencing: the byte that completes the header waits in
    // hold while the divider works; the beat is taken when it finishes.
    logic chk_wait_reg;

    // Output register.
    logic        ov_reg;
    logic        osv_reg, ofe_reg, ofd_reg;
    logic [31:0] oval_reg, orate_reg;
    logic [7:0]  och_reg, occ_reg;
    logic [3:0]  ost_reg;

    logic        out_free;
    logic        is_hdr_end;
    logic [63:0] hdr_new;
    logic [31:0] size32;
    logic        div_start, div_busy, div_done, div_zero;
    logic [15:0] expect16;
    logic [3:0]  pre_err;
    logic        take;

    assign out_free = !ov_reg || m_ready;
    assign hdr_new  = {hdr_reg[55:0], s_data_byte};
    assign size32   = {hdr_new[7:0], hdr_new[15:8], hdr_new[23:16], hdr_new[31:24]};
    assign is_hdr_end = (phase_reg == PH_CHDR) && (pos_reg >= 4'd7)
                        && (hdr_new[63:32] == TAG_DATA);
    assign expect16 = 16'(chans_reg * {3'd0, bits_reg[15:3]});

    // Checks of the data chunk header that need no division, in priority order.
    always_comb begin
        pre_err = ST_OK;
        if (seen_reg[1]) begin
            pre_err = ST_DUPLICATE;
        end else if (!seen_reg[0]) begin
            pre_err = ST_NO_FMT;
        end else if (fcode_reg != FMT_PCM && fcode_reg != FMT_FLOAT) begin
            pre_err = ST_FMT_CODE;
        end else if (chans_reg == 16'd0 || chans_reg > MaxCh) begin
            pre_err = ST_CHANNELS;
        end else if (rate_reg == 32'd0) begin
            pre_err = ST_RATE;
        end else if (bits_reg[2:0] != 3'd0 || bits_reg[15:3] == 13'd0) begin
            pre_err = ST_DEPTH;
        end else if (align_reg != expect16) begin
            pre_err = ST_ALIGN;
        end else if (size32 == 32'd0 || align_reg == 16'd0) begin
            pre_err = ST_SIZE;
        end
    end

    assign div_start = s_valid && is_hdr_end && !chk_wait_reg && !div_busy
                       && !div_done && (pre_err == ST_OK) && out_free;
    assign s_ready   = out_free && !div_start && !div_busy
                       && (!is_hdr_end || chk_wait_reg ? (div_done || !is_hdr_end) : 1'b1)
                       && !(chk_wait_reg && !div_done);
    assign take      = s_valid && s_ready;

    wavdec_modchk u_modchk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (size32),
        .divisor  (align_reg),
        .busy     (div_busy),
        .done     (div_done),
        .rem_zero (div_zero)
    );

    // Next-state logic for one byte of parsing.
    logic [3:0]  pos_next;
    logic [2:0]  phase_next;
    logic [32:0] rem_next;
    logic        pad_next;
    logic [15:0] fcode_next, chans_next, align_next, bits_next;
    logic [31:0] rate_next;
    logic [1:0]  seen_next;
    logic [31:0] asm_next;
    logic [1:0]  nbyte_next;
    logic [7:0]  chan_next;
    logic [3:0]  err_next;
    logic        got, fend;
    logic [31:0] sval, raw;
    logic [7:0]  chout;
    logic [3:0]  endst;
    logic [3:0]  p;
    logic [2:0]  bps;
    logic [32:0] rem_dec;
    logic [3:0]  data_err;

    always_comb begin
        pos_next = pos_reg; phase_next = phase_reg; rem_next = rem_reg; pad_next = pad_reg;
        fcode_next = fcode_reg; chans_next = chans_reg; align_next = align_reg;
        bits_next = bits_reg; rate_next = rate_reg; seen_next = seen_reg;
        asm_next = asm_reg; nbyte_next = nbyte_reg; chan_next = chan_reg; err_next = err_reg;
        got = 1'b0; fend = 1'b0; sval = 32'd0; chout = 8'd0;
        p = pos_reg; bps = bits_reg[5:3]; rem_dec = rem_reg - 33'd1;
        raw = asm_reg | ({24'd0, s_data_byte} << {nbyte_reg, 3'b000});
        data_err = (pre_err != ST_OK) ? pre_err
                 : (!div_zero ? ST_SIZE
                 : (fcode_reg == FMT_PCM
                    ? ((bits_reg == 16'd8 || bits_reg == 16'd16 || bits_reg == 16'd24
                        || bits_reg == 16'd32) ? ST_OK : ST_PCM_DEPTH)
                    : (bits_reg == 16'd32 ? ST_OK : ST_FLT_DEPTH)));
        case (phase_reg)
            PH_RIFF: begin
                if (pos_reg == 4'd3 && hdr_new[31:0] != TAG_RIFF) begin
                    err_next = ST_HEADER; phase_next = PH_ERR;
                end else if (pos_reg >= 4'd11) begin
                    if (hdr_new[31:0] != TAG_WAVE) begin
                        err_next = ST_HEADER; phase_next = PH_ERR;
                    end else begin
                        phase_next = PH_CHDR; pos_next = 4'd0;
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_CHDR: begin
                if (pos_reg >= 4'd7) begin
                    pos_next = 4'd0;
                    phase_next = PH_SKIP;
                    if (hdr_new[63:32] == TAG_FMT) begin
                        if (seen_reg[0]) begin
                            err_next = ST_DUPLICATE; phase_next = PH_ERR;
                        end else if (size32 < 32'd16) begin
                            err_next = ST_FMT_SMALL; phase_next = PH_ERR;
                        end else begin
                            seen_next[0] = 1'b1; phase_next = PH_FMT;
                        end
                    end else if (hdr_new[63:32] == TAG_DATA) begin
                        if (data_err != ST_OK) begin
                            err_next = data_err; phase_next = PH_ERR;
                        end else begin
                            seen_next[1] = 1'b1; asm_next = 32'd0; nbyte_next = 2'd0;
                            chan_next = 8'd0; phase_next = PH_DATA;
                        end
                    end
                    if (phase_next != PH_ERR) begin
                        rem_next = {1'b0, size32};
                        pad_next = size32[0];
                        if (size32 == 32'd0) begin
                            phase_next = size32[0] ? PH_PAD : PH_CHDR;
                        end
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_FMT: begin
                if (p < 4'd2) begin
                    fcode_next = fcode_reg | (16'(s_data_byte) << {p[0], 3'b000});
                end else if (p < 4'd4) begin
                    chans_next = chans_reg | (16'(s_data_byte) << {p[0], 3'b000});
                end else if (p < 4'd8) begin
                    rate_next = rate_reg | (32'(s_data_byte) << {p[1:0], 3'b000});
                end else if (p >= 4'd12 && p < 4'd14) begin
                    align_next = align_reg | (16'(s_data_byte) << {p[0], 3'b000});
                end else if (p >= 4'd14) begin
                    bits_next = bits_reg | (16'(s_data_byte) << {p[0], 3'b000});
                end
                rem_next = rem_dec;
                if (rem_dec == 33'd0) begin
                    pos_next = 4'd0; phase_next = pad_reg ? PH_PAD : PH_CHDR;
                end else if (p == 4'd15) begin
                    phase_next = PH_SKIP;
                end else begin
                    pos_next = p + 4'd1;
                end
            end
            PH_DATA: begin
                rem_next = rem_dec;
                if ({1'b0, nbyte_reg} + 3'd1 >= bps) begin
                    asm_next = 32'd0; nbyte_next = 2'd0;
                    if (fcode_reg == FMT_FLOAT && raw[30:23] == 8'hFF) begin
                        err_next = ST_NONFINITE; phase_next = PH_ERR;
                    end else begin
                        if (fcode_reg == FMT_FLOAT) begin
                            sval = float_to_q31(raw);
                        end else if (bps == 3'd1) begin
                            sval = {raw[7:0] ^ 8'h80, 24'd0};
                        end else if (bps == 3'd2) begin
                            sval = {raw[15:0], 16'd0};
                        end else if (bps == 3'd3) begin
                            sval = {raw[23:0], 8'd0};
                        end else begin
                            sval = raw;
                        end
                        got = 1'b1;
                        chout = chan_reg;
                        if (16'(chan_reg) + 16'd1 >= chans_reg) begin
                            fend = 1'b1; chan_next = 8'd0;
                        end else begin
                            chan_next = chan_reg + 8'd1;
                        end
                    end
                end else begin
                    asm_next = raw; nbyte_next = nbyte_reg + 2'd1;
                end
                if (phase_next != PH_ERR && rem_dec == 33'd0) begin
                    pos_next = 4'd0; phase_next = pad_reg ? PH_PAD : PH_CHDR;
                end
            end
            PH_SKIP: begin
                rem_next = rem_dec;
                if (rem_dec == 33'd0) begin
                    pos_next = 4'd0; phase_next = pad_reg ? PH_PAD : PH_CHDR;
                end
            end
            PH_PAD: begin
                pad_next = 1'b0; pos_next = 4'd0; phase_next = PH_CHDR;
            end
            default: begin
            end
        endcase
        // End status uses the state after this byte.
        if (phase_next == PH_ERR) begin
            endst = err_next;
        end else if (phase_next == PH_RIFF) begin
            endst = ST_HEADER;
        end else if (phase_next == PH_FMT || phase_next == PH_DATA
                     || phase_next == PH_SKIP) begin
            endst = ST_TRUNC;
        end else if (!seen_next[0]) begin
            endst = ST_NO_FMT;
        end else if (!seen_next[1]) begin
            endst = ST_NO_DATA;
        end else begin
            endst = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_wait_reg <= 1'b0;
        end else begin
            if (div_start) begin
                chk_wait_reg <= 1'b1;
            end else if (take) begin
                chk_wait_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && s_last_byte)) begin
            pos_reg <= 4'd0; phase_reg <= PH_RIFF; hdr_reg <= 64'd0; rem_reg <= 33'd0;
            pad_reg <= 1'b0; fcode_reg <= 16'd0; chans_reg <= 16'd0; rate_reg <= 32'd0;
            align_reg <= 16'd0; bits_reg <= 16'd0; seen_reg <= 2'd0; asm_reg <= 32'd0;
            nbyte_reg <= 2'd0; chan_reg <= 8'd0; err_reg <= 4'd0;
        end else if (take) begin
            pos_reg <= pos_next; phase_reg <= phase_next; rem_reg <= rem_next;
            pad_reg <= pad_next; fcode_reg <= fcode_next; chans_reg <= chans_next;
            rate_reg <= rate_next; align_reg <= align_next; bits_reg <= bits_next;
            seen_reg <= seen_next; asm_reg <= asm_next; nbyte_reg <= nbyte_next;
            chan_reg <= chan_next; err_reg <= err_next;
            if (phase_reg == PH_RIFF || phase_reg == PH_CHDR) begin
                hdr_reg <= hdr_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (take && (got || s_last_byte)) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
        if (take && (got || s_last_byte)) begin
            osv_reg   <= got;
            oval_reg  <= sval;
            och_reg   <= chout;
            ofe_reg   <= fend;
            occ_reg   <= (chans_next >= 16'd1 && chans_next <= MaxCh) ? chans_next[7:0] : 8'd0;
            orate_reg <= rate_next;
            ofd_reg   <= s_last_byte;
            ost_reg   <= s_last_byte ? endst : ST_OK;
        end
    end

    assign m_valid         = ov_reg;
    assign m_sample_valid  = osv_reg;
    assign m_sample_value  = oval_reg;
    assign m_channel_index = och_reg;
    assign m_frame_end     = ofe_reg;
    assign m_channel_count = occ_reg;
    assign m_rate_hz       = orate_reg;
    assign m_file_done     = ofd_reg;
    assign m_status        = ost_reg;
endmodule
`default_nettype wire
